// File: sv/nested_op_subject_tracker_unit_assert.svh
// Assertion macros for the nested op subject tracker.
// Included by the top level; no other dependencies.
`ifndef NESTED_OP_SUBJECT_TRACKER_UNIT_ASSERT_SVH
`define NESTED_OP_SUBJECT_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NOST_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NOST_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NOST_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define NOST_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// File: sv/nost_pkg.sv
// Shared types and codes for the nested op subject tracker.
// No dependencies.
package nost_pkg;
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_DENIED   = 3'd4;

  localparam logic CFG_READY   = 1'b0;
  localparam logic CFG_DESTROY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;   // capture input beat
    logic look;   // slot search and stack read
    logic exec;   // commit update and result
  } ctl_t;

  typedef struct packed {
    logic done;   // result registered
  } sts_t;
endpackage

// File: sv/nested_op_subject_tracker_unit.sv
// Top level of the nested op subject tracker: config registers, control, datapath.
// Depends on nost_pkg, nost_ctrl, nost_dp, nost_ram and the assertion header.
//
// Each input beat (begin, end or query on an owner) yields exactly one result
// beat. After the accepting edge the slot table is searched and the stack top
// is read from the subject RAM (registered read); the block then decides and
// commits, and the result is registered. Only one item is in flight, so a new
// beat is accepted only after the previous one has passed accept, search and
// commit; the RAM read latency and the one-item sequencer
// set this. A new item is taken once the previous result is
// registered; the result register frees as soon as the result beat is taken,
// and a pending result does not block acceptance when it is being taken in
// the same cycle. Nothing is accepted while rst is high. Owner masks are
// written via cfg_we, index 0 ready mask, index 1 destroying mask.
`include "nested_op_subject_tracker_unit_assert.svh"
module nested_op_subject_tracker_unit
  import nost_pkg::*;
#(
  parameter int SLOTS = 8,
  parameter int NEST_DEPTH = 8,
  parameter int OWNERS = 16,
  parameter logic [31:0] BUSY_SENTINEL = 32'h8000_0000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // cmd[1:0], owner_id[5:2], subject[69:6], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // status[2:0], top subject[66:3], idle_wake[67], pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] ready_mask, destroy_mask;
  ctl_t ctl;
  sts_t sts;
  logic [2:0]  status;
  logic [63:0] top_subj;
  logic        idle_wake;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_mask <= '0;
      destroy_mask <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_READY) ready_mask <= cfg_data;
      else destroy_mask <= cfg_data;
    end
  end

  nost_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .out_ready(m_tready),
    .out_full(m_tvalid), .sts(sts), .in_ready(s_tready), .ctl(ctl)
  );

  nost_dp #(
    .SLOTS(SLOTS), .NEST_DEPTH(NEST_DEPTH), .OWNERS(OWNERS), .BUSY_SENTINEL(BUSY_SENTINEL)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .cmd_in(s_tdata[1:0]), .owner_in(s_tdata[5:2]), .subj_in(s_tdata[69:6]),
    .ready_mask(ready_mask), .destroy_mask(destroy_mask),
    .out_ready(m_tready), .out_valid(m_tvalid),
    .status(status), .top_subj(top_subj), .idle_wake(idle_wake)
  );

  assign m_tdata = {4'd0, idle_wake, top_subj, status};

  `NOST_ASSERT_NXT(a_load_look, clk, rst, ctl.load, ctl.look)
  `NOST_ASSERT_NXT(a_exec_out, clk, rst, ctl.exec, m_tvalid)
  `NOST_ASSERT_IMP(a_no_accept_busy, clk, rst, ctl.look || ctl.exec, !s_tready)
endmodule

// File: sv/nost_ram.sv
// Generic RAM, one write port and one read port, registered read.
// No dependencies.
module nost_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/nost_ctrl.sv
// Sequencer for the subject tracker: load, look, exec, hold result.
// Depends on nost_pkg.
module nost_ctrl
  import nost_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_ready,
  input  logic out_full,
  input  sts_t sts,
  output logic in_ready,
  output ctl_t ctl
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && (!out_full || out_ready)) state_next = S_LOOK;
      S_LOOK: state_next = S_EXEC;
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = !rst && (state == S_IDLE) && (!out_full || out_ready);
    ctl.load = in_ready && in_valid;
    ctl.look = (state == S_LOOK);
    ctl.exec = (state == S_EXEC) && !sts.done;
  end
endmodule

// File: sv/nost_dp.sv
// Datapath: slot table, subject stack RAM, per-owner counters, result register.
// Depends on nost_pkg and nost_ram.
module nost_dp
  import nost_pkg::*;
#(
  parameter int SLOTS = 8,
  parameter int NEST_DEPTH = 8,
  parameter int OWNERS = 16,
  parameter logic [31:0] BUSY_SENTINEL = 32'h8000_0000
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  logic [1:0]  cmd_in,
  input  logic [3:0]  owner_in,
  input  logic [63:0] subj_in,
  input  logic [15:0] ready_mask,
  input  logic [15:0] destroy_mask,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  status,
  output logic [63:0] top_subj,
  output logic        idle_wake
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW = $clog2(NEST_DEPTH + 1);
  localparam int AW = $clog2(SLOTS * NEST_DEPTH) > 0 ? $clog2(SLOTS * NEST_DEPTH) : 1;
  localparam int RD = (SLOTS * NEST_DEPTH > 1) ? SLOTS * NEST_DEPTH : 2;
  // owner ids are 4 bits, so at most 16 counters are ever reachable
  localparam int NOWN = (OWNERS < 16) ? OWNERS : 16;
  localparam int OB = $clog2(NOWN);

  logic [1:0]  cmd;
  logic [3:0]  owner;
  logic [63:0] subj;
  logic [3:0]  slot_owner [SLOTS];
  logic [DW-1:0] slot_depth [SLOTS];
  logic [31:0] active_count [NOWN];

  // look stage results
  logic          hit, hit_c, free_ok, free_c;
  logic [SW-1:0] hit_slot, hit_c_s, free_slot, free_c_s;
  logic [DW-1:0] hit_depth;
  logic [31:0]   cnt;
  logic [AW-1:0] raddr;
  logic [63:0]   top;

  // write port
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= cmd_in;
      owner <= owner_in;
      subj <= subj_in;
    end
  end

  always_comb begin
    hit_c = 1'b0;
    hit_c_s = '0;
    free_c = 1'b0;
    free_c_s = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_owner[i] == owner && slot_depth[i] != '0) begin
        hit_c = 1'b1;
        hit_c_s = SW'(i);
      end
      if (slot_depth[i] == '0) begin
        free_c = 1'b1;
        free_c_s = SW'(i);
      end
    end
  end

  // stack top address: slot * NEST_DEPTH + depth - 1
  always_comb begin
    raddr = AW'(32'(hit_c_s) * NEST_DEPTH + 32'(slot_depth[hit_c_s]) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (ctl.look) begin
      hit <= hit_c;
      hit_slot <= hit_c_s;
      hit_depth <= slot_depth[hit_c_s];
      free_ok <= free_c;
      free_slot <= free_c_s;
      cnt <= (32'(owner) < OWNERS) ? active_count[owner[OB-1:0]] : '0;
    end
  end

  nost_ram #(.WIDTH(64), .DEPTH(RD)) u_stack (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(top)
  );

  logic valid_o, ready_o, destr;
  logic [63:0] cur;
  logic [2:0]  st;
  logic        wake, cnt_up, cnt_dn, push_hit, push_new, pop;
  logic [31:0] cnt_new;

  always_comb begin
    valid_o = owner != 4'd0 && 32'(owner) < OWNERS;
    ready_o = valid_o && ready_mask[owner];
    destr = destroy_mask[owner];
    cur = hit ? top : 64'd0;
    st = ST_INVALID;
    wake = 1'b0;
    cnt_up = 1'b0;
    cnt_dn = 1'b0;
    push_hit = 1'b0;
    push_new = 1'b0;
    pop = 1'b0;
    cnt_new = cnt;
    case (cmd)
      CMD_BEGIN: begin
        if (!ready_o || (destr && !hit)) st = ST_INVALID;
        else if (cnt >= BUSY_SENTINEL - 32'd1) st = ST_BUSY;
        else if (hit && 32'(hit_depth) >= NEST_DEPTH) st = ST_OVERFLOW;
        else if (!hit && !free_ok) st = ST_OVERFLOW;
        else if (hit && subj != 64'd0 && cur != 64'd0 && cur != subj) st = ST_DENIED;
        else begin
          st = ST_OK;
          cnt_up = 1'b1;
          cnt_new = cnt + 32'd1;
          push_hit = hit;
          push_new = !hit;
        end
      end
      CMD_END: begin
        if (ready_o) begin
          st = ST_OK;
          if (cnt < BUSY_SENTINEL && cnt != 32'd0) begin
            cnt_dn = 1'b1;
            cnt_new = cnt - 32'd1;
          end
          pop = hit;
          wake = destr && cnt_new == 32'd0;
        end
      end
      CMD_QUERY: begin
        if (valid_o) st = ST_OK;
      end
      default: st = ST_INVALID;
    endcase
    we = ctl.exec && (push_hit || push_new || pop);
    if (push_new) begin
      waddr = AW'(32'(free_slot) * NEST_DEPTH);
      wdata = subj;
    end else if (push_hit) begin
      waddr = AW'(32'(hit_slot) * NEST_DEPTH + 32'(hit_depth));
      wdata = (subj != 64'd0) ? subj : cur;
    end else begin
      waddr = AW'(32'(hit_slot) * NEST_DEPTH + 32'(hit_depth) - 32'd1);
      wdata = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_owner[i] <= '0;
        slot_depth[i] <= '0;
      end
      for (int k = 0; k < NOWN; k++) active_count[k] <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.exec) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (ctl.exec) begin
        status <= st;
        top_subj <= (cmd == CMD_QUERY) ? cur : 64'd0;
        idle_wake <= wake;
        if (cnt_up || cnt_dn) active_count[owner[OB-1:0]] <= cnt_new;
        if (push_new) begin
          slot_owner[free_slot] <= owner;
          slot_depth[free_slot] <= DW'(1);
        end
        if (push_hit) slot_depth[hit_slot] <= hit_depth + DW'(1);
        if (pop) begin
          slot_depth[hit_slot] <= hit_depth - DW'(1);
          if (hit_depth == DW'(1)) slot_owner[hit_slot] <= '0;
        end
      end
    end
  end

  assign sts.done = 1'b0;
endmodule

// File: dv/nested_op_subject_tracker_unit_tb.sv
// Testbench for nested_op_subject_tracker_unit: directed table, then random stream.
// Depends on nost_pkg and the RTL top; results checked against an in-bench predictor.
module nested_op_subject_tracker_unit_tb
  import nost_pkg::*;
;

  localparam int NSLOT = 8;
  localparam int NDEPTH = 8;
  localparam int NOWN = 16;
  localparam logic [31:0] SENTINEL = 32'h8000_0000;
  localparam int LIMIT = 400000;

  // packed from the msb down: wake, subject, status
  typedef struct packed {
    logic        wake;
    logic [63:0] subject;
    logic [2:0]  status;
  } result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  owner;
    logic [63:0] subj;
    logic        has_exp;
    logic [2:0]  exp_status;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [15:0] cfg_data = '0;

  // predictor state
  logic [15:0] ready_mask, destroy_mask;
  logic [3:0]  slot_own [NSLOT];
  logic [3:0]  slot_dep [NSLOT];
  logic [63:0] stack_mem [NSLOT*NDEPTH];
  logic [31:0] op_count [NOWN];

  result_t     pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  int          hold_off = 0;   // long receiver stall, in cycles
  logic [63:0] subj_pool [4];

  nested_op_subject_tracker_unit u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int find_slot(logic [3:0] own);
    for (int i = 0; i < NSLOT; i++)
      if (slot_own[i] == own && slot_dep[i] != 0) return i;
    return NSLOT;
  endfunction

  // Compute the result of one beat and update the predicted state.
  function automatic result_t track_step(logic [1:0] cmd, logic [3:0] own, logic [63:0] subj);
    result_t r;
    int s, fs;
    logic ready;
    logic [63:0] top;
    r = '{status: ST_INVALID, subject: '0, wake: 1'b0};
    ready = own != 0 && ready_mask[own];
    s = find_slot(own);
    case (cmd)
      CMD_BEGIN: begin
        if (!ready) r.status = ST_INVALID;
        else if (destroy_mask[own] && s == NSLOT) r.status = ST_INVALID;
        else if (op_count[own] >= SENTINEL - 1) r.status = ST_BUSY;
        else if (s != NSLOT) begin
          if (slot_dep[s] >= NDEPTH) r.status = ST_OVERFLOW;
          else begin
            top = stack_mem[s*NDEPTH + slot_dep[s] - 1];
            if (subj != 0 && top != 0 && top != subj) r.status = ST_DENIED;
            else begin
              stack_mem[s*NDEPTH + slot_dep[s]] = subj != 0 ? subj : top;
              slot_dep[s]++;
              op_count[own]++;
              r.status = ST_OK;
            end
          end
        end else begin
          fs = NSLOT;
          for (int i = NSLOT - 1; i >= 0; i--) if (slot_dep[i] == 0) fs = i;
          if (fs == NSLOT) r.status = ST_OVERFLOW;
          else begin
            slot_own[fs] = own;
            slot_dep[fs] = 1;
            stack_mem[fs*NDEPTH] = subj;
            op_count[own]++;
            r.status = ST_OK;
          end
        end
      end
      CMD_END: begin
        if (ready) begin
          r.status = ST_OK;
          if (op_count[own] < SENTINEL && op_count[own] > 0) op_count[own]--;
          if (s != NSLOT) begin
            slot_dep[s]--;
            stack_mem[s*NDEPTH + slot_dep[s]] = '0;
            if (slot_dep[s] == 0) slot_own[s] = '0;
          end
          r.wake = destroy_mask[own] && op_count[own] == 0;
        end
      end
      CMD_QUERY: begin
        if (own != 0) begin
          r.status = ST_OK;
          if (s != NSLOT) r.subject = stack_mem[s*NDEPTH + slot_dep[s] - 1];
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_READY) ready_mask = val;
    else destroy_mask = val;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // One beat; the predictor runs at acceptance.
  task automatic send_beat(logic [1:0] cmd, logic [3:0] own, logic [63:0] subj,
                           logic has_exp, logic [2:0] exp_status);
    result_t r;
    s_tvalid <= 1;
    s_tdata <= {2'b0, subj, own, cmd};
    do @(posedge clk); while (!s_tready);
    r = track_step(cmd, own, subj);
    if (has_exp && r.status != exp_status) begin
      $error("status: expected %0d actual %0d (directed row vs predictor)",
             exp_status, r.status);
      errors++;
    end
    pending_results.push_back(r);
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 3);
    if (n != 0) begin
      s_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: stall pattern plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else
      m_tready <= (cycles[6:5] == 2'b00) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[67:0];
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status);
          errors++;
        end
        if (got.subject !== want.subject) begin
          $error("top_subj: expected %h actual %h", want.subject, got.subject);
          errors++;
        end
        if (got.wake !== want.wake) begin
          $error("idle_wake: expected %0d actual %0d", want.wake, got.wake);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] pick_subject();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {$urandom, $urandom};
      default: return subj_pool[$urandom_range(0, 3)];
    endcase
  endfunction

  initial begin
    row_t rows[$];
    int burst;
    logic [1:0] c;
    logic [3:0] o;
    ready_mask = '0;
    destroy_mask = '0;
    foreach (slot_own[i]) begin
      slot_own[i] = '0;
      slot_dep[i] = '0;
    end
    foreach (stack_mem[i]) stack_mem[i] = '0;
    foreach (op_count[i]) op_count[i] = '0;
    subj_pool = '{64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5_5A5A_0F0F_F0F0, 64'h8000_0000_0000_0000};

    repeat (2) @(posedge clk);
    rst <= 0;

    // after reset: nothing ready
    rows.push_back('{CMD_BEGIN, 4'd1, 64'd5, 1, ST_INVALID});
    rows.push_back('{CMD_END,   4'd1, 64'd0, 1, ST_INVALID});
    rows.push_back('{CMD_QUERY, 4'd0, 64'd0, 1, ST_INVALID});
    rows.push_back('{CMD_QUERY, 4'd3, 64'd0, 1, ST_OK});
    rows.push_back('{2'd3,      4'd3, 64'd0, 1, ST_INVALID});
    foreach (rows[i])
      send_beat(rows[i].cmd, rows[i].owner, rows[i].subj,
                rows[i].has_exp, rows[i].exp_status);
    drain();

    write_reg(CFG_READY, 16'hFFFF);
    write_reg(CFG_DESTROY, 16'h8000);
    rows = {};
    rows.push_back('{CMD_BEGIN, 4'd0,  64'd7, 1, ST_INVALID});
    rows.push_back('{CMD_BEGIN, 4'd15, 64'd7, 1, ST_INVALID});   // destroying, no slot
    rows.push_back('{CMD_BEGIN, 4'd2,  64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK});
    rows.push_back('{CMD_BEGIN, 4'd2,  64'd0, 1, ST_OK});        // inherit
    rows.push_back('{CMD_BEGIN, 4'd2,  64'd9, 1, ST_DENIED});
    rows.push_back('{CMD_QUERY, 4'd2,  64'd0, 0, ST_OK});
    for (int k = 0; k < 7; k++) rows.push_back('{CMD_BEGIN, 4'd2, 64'd0, 0, ST_OK});
    rows.push_back('{CMD_END,   4'd2,  64'd0, 1, ST_OK});
    rows.push_back('{CMD_END,   4'd4,  64'd0, 1, ST_OK});        // no slot, count zero
    rows.push_back('{CMD_BEGIN, 4'd3,  64'd0, 1, ST_OK});        // zero subject on new slot
    rows.push_back('{CMD_BEGIN, 4'd3,  64'd11, 1, ST_OK});
    foreach (rows[i])
      send_beat(rows[i].cmd, rows[i].owner, rows[i].subj,
                rows[i].has_exp, rows[i].exp_status);
    gap();
    drain();

    // random phases with varied masks, extremes first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_READY, 16'hFFFF); write_reg(CFG_DESTROY, 16'h0000); end
        1: begin write_reg(CFG_READY, 16'h00FF); write_reg(CFG_DESTROY, 16'hFFFF); end
        default: begin
          write_reg(CFG_READY, 16'($urandom) | 16'h0F0F);
          write_reg(CFG_DESTROY, 16'($urandom) & 16'($urandom));
        end
      endcase
      if (ph == 2) hold_off = 300;
      for (int n = 0; n < 150;) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 150; b++, n++) begin
          c = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
          if (c == CMD_BEGIN && $urandom_range(0, 1)) c = CMD_BEGIN;
          o = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 5));
          send_beat(c, o, pick_subject(), 0, ST_OK);
        end
        gap();
      end
      drain();
    end

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
